[rtl/distance_median_classifier_unit_defines.svh]
// ----------------------------------------------------------------------------
// Distance median classifier assertion macros
// Concurrent assertion helpers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_MEDIAN_CLASSIFIER_UNIT_DEFINES_SVH
`define DISTANCE_MEDIAN_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define DMC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define DMC_ASSERT_IMP(lbl, ante, cons)
`define DMC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// Distance median classifier package
// Shared types, constants and a helper function of the classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmc_pkg;

	localparam int DIST_W      = 16;
	localparam int DEF_WINDOW  = 5;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int HOLD_W      = 4;
	localparam int LED_W       = 8;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic [DIST_W-1:0] DEF_WARN   = 16'd1600;
	localparam logic [DIST_W-1:0] DEF_ALERT  = 16'd480;
	localparam logic [HOLD_W-1:0] DEF_HOLD   = 4'd3;
	localparam logic [LED_W-1:0]  DEF_BRIGHT = 8'd40;

	typedef enum logic [1:0] {
		CLS_ERROR  = 2'd0,
		CLS_NORMAL = 2'd1,
		CLS_WARN   = 2'd2,
		CLS_ALERT  = 2'd3
	} dmc_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WARN   = 2'd0,
		REG_ALERT  = 2'd1,
		REG_HOLD   = 2'd2,
		REG_BRIGHT = 2'd3
	} dmc_reg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SCAN,
		F_PUSH
	} dmc_fstate_t;

	typedef struct packed {
		logic              sample_valid;
		logic [DIST_W-1:0] distance;
	} dmc_in_t;

	typedef struct packed {
		logic              median_valid;
		logic [DIST_W-1:0] median_distance;
		logic [1:0]        stable_state;
		logic [LED_W-1:0]  led_red;
		logic [LED_W-1:0]  led_green;
		logic [LED_W-1:0]  led_blue;
	} dmc_out_t;

	typedef struct packed {
		logic              have;
		logic [DIST_W-1:0] median;
		dmc_class_t        cls;
	} dmc_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] warn;
		logic [DIST_W-1:0] alert;
	} dmc_thr_t;

	typedef struct packed {
		logic [HOLD_W-1:0] hold;
		logic [LED_W-1:0]  bright;
	} dmc_bcfg_t;

	// Exact floor(x / 5) for x below 1024.
	function automatic logic [LED_W-1:0] div5(input logic [9:0] x);
		logic [17:0] p;
		p = {8'd0, x} * 18'd205;
		return p[17:10];
	endfunction

endpackage

[rtl/dmc_front.sv]
// ----------------------------------------------------------------------------
// Distance median classifier front end
// Accepts samples into the ring, selects the upper median and classifies it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "distance_median_classifier_unit_defines.svh"

module dmc_front import dmc_pkg::*; #(
	parameter int WINDOW = DEF_WINDOW
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      smp_valid,
	output logic      smp_stall,
	input  dmc_in_t   smp,
	input  dmc_thr_t  thr,
	input  logic      q_full,
	output logic      push,
	output dmc_item_t push_item
);

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	logic              ring_vld_q  [WINDOW];
	logic [DIST_W-1:0] ring_dist_q [WINDOW];
	logic [IDX_W-1:0]  wp_q;
	logic              full_q;
	logic [IDX_W-1:0]  idx_q;
	logic              have_q;
	logic [DIST_W-1:0] med_q;
	dmc_fstate_t       st_q, st_n;

	logic              accept;
	logic [WINDOW-1:0] usable;
	logic [CNT_W-1:0]  n_cnt, lt_cnt, le_cnt, half;
	logic [DIST_W-1:0] cand;
	logic              hit;
	dmc_class_t        cls;

	assign accept = smp_valid && !smp_stall;

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			usable[i] = ring_vld_q[i] && (ring_dist_q[i] != '0) &&
				(full_q || (IDX_W'(i) < wp_q));
		end
	end

	assign cand = ring_dist_q[idx_q];

	always_comb begin
		n_cnt  = '0;
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < WINDOW; j++) begin
			n_cnt  = n_cnt + CNT_W'(usable[j]);
			lt_cnt = lt_cnt + CNT_W'(usable[j] && (ring_dist_q[j] < cand));
			le_cnt = le_cnt + CNT_W'(usable[j] && (ring_dist_q[j] <= cand));
		end
	end

	assign half = n_cnt >> 1;
	assign hit  = usable[idx_q] && (lt_cnt <= half) && (half < le_cnt);

	always_comb begin
		if (!have_q) begin
			cls = CLS_ERROR;
		end else if (med_q > thr.warn) begin
			cls = CLS_NORMAL;
		end else if (med_q > thr.alert) begin
			cls = CLS_WARN;
		end else begin
			cls = CLS_ALERT;
		end
	end

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			F_IDLE: begin
				if (smp_valid) begin
					st_n = F_SCAN;
				end
			end
			F_SCAN: begin
				if (idx_q == LAST_IDX) begin
					st_n = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					st_n = F_IDLE;
				end
			end
			default: st_n = F_IDLE;
		endcase
	end

	always_comb begin
		smp_stall = 1'b1;
		push      = 1'b0;
		unique case (st_q)
			F_IDLE:  smp_stall = 1'b0;
			F_SCAN:  smp_stall = 1'b1;
			F_PUSH:  push = !q_full;
			default: smp_stall = 1'b1;
		endcase
	end

	assign push_item.have   = have_q;
	assign push_item.median = med_q;
	assign push_item.cls    = cls;

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_vld_q[wp_q]  <= smp.sample_valid;
			ring_dist_q[wp_q] <= smp.distance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			wp_q   <= '0;
			full_q <= 1'b0;
			idx_q  <= '0;
			have_q <= 1'b0;
			med_q  <= '0;
		end else begin
			st_q <= st_n;
			if (accept) begin
				idx_q  <= '0;
				have_q <= 1'b0;
				med_q  <= '0;
				if (wp_q == LAST_IDX) begin
					wp_q   <= '0;
					full_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end else if (st_q == F_SCAN) begin
				if (hit) begin
					have_q <= 1'b1;
					med_q  <= cand;
				end
				if (idx_q != LAST_IDX) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	`DMC_ASSERT_NXT(a_scan_after_accept, accept, st_q == F_SCAN)
	`DMC_ASSERT_IMP(a_wp_in_range, 1'b1, wp_q <= LAST_IDX)
	`DMC_ASSERT_IMP(a_median_nonzero, (st_q == F_PUSH) && have_q, med_q != '0)

endmodule

[rtl/dmc_queue.sv]
// ----------------------------------------------------------------------------
// Distance median classifier queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "distance_median_classifier_unit_defines.svh"

module dmc_queue import dmc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  dmc_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output dmc_item_t pop_item
);

	dmc_item_t          mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`DMC_ASSERT_IMP(a_no_overflow, push, !full)
	`DMC_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

[rtl/dmc_back.sv]
// ----------------------------------------------------------------------------
// Distance median classifier back end
// Debounces the class into the stable state and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "distance_median_classifier_unit_defines.svh"

module dmc_back import dmc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dmc_bcfg_t bcfg,
	input  logic      q_empty,
	input  dmc_item_t q_item,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output dmc_out_t  res
);

	dmc_class_t        stable_q, cand_q;
	logic [HOLD_W-1:0] run_q;
	logic              res_valid_q;
	dmc_out_t          res_q;

	dmc_class_t        stable_n, cand_n;
	logic [HOLD_W-1:0] run_n;
	logic [9:0]        b3, b4;
	dmc_out_t          res_n;

	assign pop       = !q_empty && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		if (q_item.cls == cand_q) begin
			cand_n = cand_q;
			run_n  = (run_q < bcfg.hold) ? run_q + 1'b1 : run_q;
		end else begin
			cand_n = q_item.cls;
			run_n  = HOLD_W'(1);
		end
		stable_n = (run_n >= bcfg.hold) ? cand_n : stable_q;
	end

	assign b3 = {2'b00, bcfg.bright} + {1'b0, bcfg.bright, 1'b0};
	assign b4 = {bcfg.bright, 2'b00};

	always_comb begin
		res_n.median_valid    = q_item.have;
		res_n.median_distance = q_item.median;
		res_n.stable_state    = stable_n;
		res_n.led_red         = '0;
		res_n.led_green       = '0;
		res_n.led_blue        = '0;
		unique case (stable_n)
			CLS_ERROR:  res_n.led_blue = bcfg.bright;
			CLS_NORMAL: res_n.led_green = bcfg.bright;
			CLS_WARN: begin
				res_n.led_red   = div5(b3);
				res_n.led_green = div5(b4);
			end
			CLS_ALERT:  res_n.led_red = bcfg.bright;
			default:    res_n.led_blue = bcfg.bright;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q    <= CLS_NORMAL;
			cand_q      <= CLS_NORMAL;
			run_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				stable_q    <= stable_n;
				cand_q      <= cand_n;
				run_q       <= run_n;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`DMC_ASSERT_NXT(a_stable_held, !pop, $stable(stable_q))
	`DMC_ASSERT_NXT(a_pop_gives_result, pop, res_valid_q)

endmodule

[rtl/distance_median_classifier_unit.sv]
// A result reaches the back end's result register after its sample has passed the front
// end's scan and push states and the queue. No new sample is taken until the median scan,
// which tests one ring entry per cycle, and the queue push are done.
// Reset: thresholds, hold count and brightness take their defaults, the ring is empty
// and the stable state is normal; there is no clearing pass.
// ----------------------------------------------------------------------------
// Distance median classifier top level
// Configuration registers, median front end, queue and debounce back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distance_median_classifier_unit import dmc_pkg::*; #(
	parameter int WINDOW = DEF_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 smp_valid,
	output logic                 smp_stall,
	input  dmc_in_t              smp,
	output logic                 res_valid,
	input  logic                 res_stall,
	output dmc_out_t             res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dmc_thr_t  thr_q;
	dmc_bcfg_t bcfg_q;

	logic      push, pop, q_full, q_empty;
	dmc_item_t push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.warn    <= DEF_WARN;
			thr_q.alert   <= DEF_ALERT;
			bcfg_q.hold   <= DEF_HOLD;
			bcfg_q.bright <= DEF_BRIGHT;
		end else if (cfg_we) begin
			unique case (dmc_reg_t'(cfg_index))
				REG_WARN:   thr_q.warn <= cfg_data[DIST_W-1:0];
				REG_ALERT:  thr_q.alert <= cfg_data[DIST_W-1:0];
				REG_HOLD:   bcfg_q.hold <= cfg_data[HOLD_W-1:0];
				REG_BRIGHT: bcfg_q.bright <= cfg_data[LED_W-1:0];
				default:    thr_q <= thr_q;
			endcase
		end
	end

	dmc_front #(
		.WINDOW(WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.thr       (thr_q),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	dmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_item  (pop_item)
	);

	dmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.bcfg      (bcfg_q),
		.q_empty   (q_empty),
		.q_item    (pop_item),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
